/* hw/rtl/qrfo_pkg.sv */
`default_nettype none
package qrfo_pkg;

    localparam int DIV_BITS  = 4;
    localparam int QUO_W     = 32;
    localparam int DV_W      = 34;
    localparam int REM_W     = 34;
    localparam int NUM_W     = 55;
    localparam int SUM_W     = 34;
    localparam int NORM_W    = 33;
    localparam int PROD_W    = 32;
    localparam int FRAC_SHIFT = 22;
    localparam int N_DIV_ST  = QUO_W / DIV_BITS;

    // Term sign per output row, bit [k][j] set when term j of row k is subtracted.
    localparam logic [3:0][2:0] ROW_NEG = 12'b111_001_100_010;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        logic signed [15:0] wz;
    } in_t;

    typedef struct packed {
        logic [3:0][2:0][PROD_W-1:0] term;
        logic [3:0][PROD_W-1:0]      sq;
    } prod_t;

    typedef struct packed {
        logic [3:0][SUM_W-1:0] s;
        logic [NORM_W-1:0]     d;
    } sum_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] num_lo;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t [3:0]     lane;
        logic [DV_W-1:0] dv;
        logic            zero;
    } div_t;

endpackage
`default_nettype wire

/* hw/rtl/quaternion_rate_from_omega.sv */
// Throughput: one word per cycle unless m_tready stalls the pipeline; the 8-stage
// divider array (4 quotient bits per stage, one lane per rate) sets the depth.
// Reset: aresetn, synchronous, active low; clears all stage valid bits,
// datapath registers are not reset.
`default_nettype none
module quaternion_rate_from_omega
    import qrfo_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // quat_x, quat_y, quat_z, quat_w, omega_x, omega_y, omega_z (16 bits each)
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // rate_x, rate_y, rate_z, rate_w (32 bits each)
    output logic [127:0]      m_tdata,
    // zero_norm
    output logic              m_tuser
);

    // Stage map: 0 products, 1 sums, 2 divider setup, 3.. divider, last output.
    localparam int NST = 3 + N_DIV_ST + 1;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] rdy;

    in_t   in_word;
    prod_t prod_q;
    sum_t  sum_q;
    div_t  div_q [N_DIV_ST+1];

    logic [3:0][QUO_W-1:0] rate_next;
    logic [3:0][QUO_W-1:0] rate_reg;
    logic                  zero_reg;

    // A stage advances when it is empty or its successor advances.
    always_comb begin
        rdy[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NST; i++) begin
            if (rdy[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];

    // Unpack the input word, first field lowest.
    assign in_word.qx = s_tdata[15:0];
    assign in_word.qy = s_tdata[31:16];
    assign in_word.qz = s_tdata[47:32];
    assign in_word.qw = s_tdata[63:48];
    assign in_word.wx = s_tdata[79:64];
    assign in_word.wy = s_tdata[95:80];
    assign in_word.wz = s_tdata[111:96];

    qrfo_prod u_prod (
        .aclk (aclk),
        .en   (rdy[0]),
        .din  (in_word),
        .dout (prod_q)
    );

    qrfo_sum u_sum (
        .aclk (aclk),
        .en   (rdy[1]),
        .din  (prod_q),
        .dout (sum_q)
    );

    qrfo_prep u_prep (
        .aclk (aclk),
        .en   (rdy[2]),
        .din  (sum_q),
        .dout (div_q[0])
    );

    for (genvar g = 0; g < N_DIV_ST; g++) begin : g_div
        qrfo_div_stage u_div (
            .aclk (aclk),
            .en   (rdy[3+g]),
            .din  (div_q[g]),
            .dout (div_q[g+1])
        );
    end

    // Apply sign and saturate; force zero on a zero norm.
    always_comb begin
        lane_t ln;
        for (int k = 0; k < 4; k++) begin
            ln = div_q[N_DIV_ST].lane[k];
            if (div_q[N_DIV_ST].zero) begin
                rate_next[k] = '0;
            end else if (ln.neg) begin
                if (ln.ovf || (ln.quo > {1'b1, {(QUO_W-1){1'b0}}})) begin
                    rate_next[k] = {1'b1, {(QUO_W-1){1'b0}}};
                end else begin
                    rate_next[k] = QUO_W'(0) - ln.quo;
                end
            end else begin
                if (ln.ovf || ln.quo[QUO_W-1]) begin
                    rate_next[k] = {1'b0, {(QUO_W-1){1'b1}}};
                end else begin
                    rate_next[k] = ln.quo;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NST-1]) begin
            rate_reg <= rate_next;
            zero_reg <= div_q[N_DIV_ST].zero;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {rate_reg[3], rate_reg[2], rate_reg[1], rate_reg[0]};
    assign m_tuser  = zero_reg;

`ifndef SYNTHESIS
    a_zero_forces_rates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero norm word carries nonzero rates");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !vld_reg[0])
        else $error("valid bits survive reset");

    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("pipeline stalls while sink is ready");

    a_valid_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NST-2] && rdy[NST-1] |=> m_tvalid)
        else $error("word lost at output stage");
`endif

endmodule
`default_nettype wire

/* hw/rtl/qrfo_prod.sv */
`default_nettype none
module qrfo_prod
    import qrfo_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire in_t   din,
    output prod_t      dout
);

    prod_t prod_next;
    prod_t prod_reg;

    always_comb begin
        prod_next.term[0][0] = PROD_W'(din.qw * din.wx);
        prod_next.term[0][1] = PROD_W'(din.qz * din.wy);
        prod_next.term[0][2] = PROD_W'(din.qy * din.wz);
        prod_next.term[1][0] = PROD_W'(din.qz * din.wx);
        prod_next.term[1][1] = PROD_W'(din.qw * din.wy);
        prod_next.term[1][2] = PROD_W'(din.qx * din.wz);
        prod_next.term[2][0] = PROD_W'(din.qy * din.wx);
        prod_next.term[2][1] = PROD_W'(din.qx * din.wy);
        prod_next.term[2][2] = PROD_W'(din.qw * din.wz);
        prod_next.term[3][0] = PROD_W'(din.qx * din.wx);
        prod_next.term[3][1] = PROD_W'(din.qy * din.wy);
        prod_next.term[3][2] = PROD_W'(din.qz * din.wz);
        prod_next.sq[0]      = PROD_W'(din.qx * din.qx);
        prod_next.sq[1]      = PROD_W'(din.qy * din.qy);
        prod_next.sq[2]      = PROD_W'(din.qz * din.qz);
        prod_next.sq[3]      = PROD_W'(din.qw * din.qw);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign dout = prod_reg;

endmodule
`default_nettype wire

/* hw/rtl/qrfo_sum.sv */
`default_nettype none
module qrfo_sum
    import qrfo_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire prod_t din,
    output sum_t       dout
);

    sum_t sum_next;
    sum_t sum_reg;

    always_comb begin
        logic signed [SUM_W-1:0] t;
        sum_next.d = NORM_W'(din.sq[0]) + NORM_W'(din.sq[1])
                   + NORM_W'(din.sq[2]) + NORM_W'(din.sq[3]);
        for (int k = 0; k < 4; k++) begin
            sum_next.s[k] = '0;
            for (int j = 0; j < 3; j++) begin
                t = SUM_W'($signed(din.term[k][j]));
                // subtract where the row calls for it
                if (ROW_NEG[k][j]) begin
                    sum_next.s[k] = sum_next.s[k] - t;
                end else begin
                    sum_next.s[k] = sum_next.s[k] + t;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign dout = sum_reg;

endmodule
`default_nettype wire

/* hw/rtl/qrfo_prep.sv */
`default_nettype none
module qrfo_prep
    import qrfo_pkg::*;
(
    input  wire logic aclk,
    input  wire logic en,
    input  wire sum_t din,
    output div_t      dout
);

    div_t div_next;
    div_t div_reg;

    always_comb begin
        logic [SUM_W-1:0] abs_s;
        logic [NUM_W-1:0] num;
        div_next.dv   = {din.d, 1'b0};
        div_next.zero = (din.d == '0);
        for (int k = 0; k < 4; k++) begin
            div_next.lane[k].neg = din.s[k][SUM_W-1];
            abs_s = din.s[k][SUM_W-1] ? (SUM_W'(0) - din.s[k]) : din.s[k];
            // numerator = 2^22 * |S| + D, carries the rounding half
            num = {NUM_W'(abs_s[QUO_W-1:0]) << FRAC_SHIFT} + NUM_W'(din.d);
            div_next.lane[k].rem    = REM_W'(num[NUM_W-1:QUO_W]);
            div_next.lane[k].num_lo = num[QUO_W-1:0];
            div_next.lane[k].quo    = '0;
            div_next.lane[k].ovf    = DV_W'(num[NUM_W-1:QUO_W]) >= {din.d, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
        end
    end

    assign dout = div_reg;

endmodule
`default_nettype wire

/* hw/rtl/qrfo_div_stage.sv */
`default_nettype none
module qrfo_div_stage
    import qrfo_pkg::*;
(
    input  wire logic aclk,
    input  wire logic en,
    input  wire div_t din,
    output div_t      dout
);

    div_t stg_next;
    div_t stg_reg;

    // Restoring division, DIV_BITS quotient bits per lane.
    always_comb begin
        logic [REM_W:0] trial;
        logic           qbit;
        stg_next = din;
        for (int l = 0; l < 4; l++) begin
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {stg_next.lane[l].rem, stg_next.lane[l].num_lo[QUO_W-1]};
                qbit  = trial >= {1'b0, stg_next.dv};
                if (qbit) begin
                    trial = trial - {1'b0, stg_next.dv};
                end
                stg_next.lane[l].rem    = trial[REM_W-1:0];
                stg_next.lane[l].num_lo = {stg_next.lane[l].num_lo[QUO_W-2:0], 1'b0};
                stg_next.lane[l].quo    = {stg_next.lane[l].quo[QUO_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg <= stg_next;
        end
    end

    assign dout = stg_reg;

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
module tb;

    // Pack order on both buses: first field in the lowest bits.
    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // quat_x, quat_y, quat_z, quat_w, omega_x, omega_y, omega_z (16 bits each)
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // rate_x, rate_y, rate_z, rate_w (32 bits each)
    logic [127:0] m_tdata;
    // zero_norm
    logic         m_tuser;

    typedef struct packed {
        logic [127:0] rates;
        logic         zero;
    } rate_word_t;

    rate_word_t   rate_fifo[$];
    int           mismatches = 0;
    int           cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 14;
    localparam int N_RANDOM    = 950;

    quaternion_rate_from_omega dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Scale one row sum into Q16.16: round half away from zero, then saturate.
    function automatic logic [31:0] scale_q16(longint s, longint d);
        logic         neg;
        logic [63:0]  mag;
        logic [63:0]  q;
        neg = s < 0;
        mag = neg ? -s : s;
        q = (mag * 64'd4194304 + d) / (2 * d);
        if (neg) begin
            if (q > 64'd2147483648) q = 64'd2147483648;
            return 32'(-q);
        end
        if (q > 64'd2147483647) q = 64'd2147483647;
        return q[31:0];
    endfunction

    function automatic rate_word_t quat_rate(logic [111:0] w);
        longint qx, qy, qz, qw, wx, wy, wz, d;
        rate_word_t r;
        qx = longint'($signed(w[15:0]));
        qy = longint'($signed(w[31:16]));
        qz = longint'($signed(w[47:32]));
        qw = longint'($signed(w[63:48]));
        wx = longint'($signed(w[79:64]));
        wy = longint'($signed(w[95:80]));
        wz = longint'($signed(w[111:96]));
        d = qx*qx + qy*qy + qz*qz + qw*qw;
        r = '0;
        if (d == 0) begin
            r.zero = 1'b1;
            return r;
        end
        r.rates[31:0]   = scale_q16( qw*wx - qz*wy + qy*wz, d);
        r.rates[63:32]  = scale_q16( qz*wx + qw*wy - qx*wz, d);
        r.rates[95:64]  = scale_q16(-qy*wx + qx*wy + qw*wz, d);
        r.rates[127:96] = scale_q16(-qx*wx - qy*wy - qz*wz, d);
        return r;
    endfunction

    function automatic logic [111:0] pack_word(int q0, int q1, int q2, int q3,
                                               int w0, int w1, int w2);
        return {16'(w2), 16'(w1), 16'(w0), 16'(q3), 16'(q2), 16'(q1), 16'(q0)};
    endfunction

    // Directed rows; a row with has_exp set carries a result readable at a glance.
    typedef struct {
        logic [111:0] word;
        logic         has_exp;
        rate_word_t   exp;
    } directed_row_t;

    directed_row_t directed[N_DIRECTED];

    initial begin
        directed[0]  = '{pack_word(0, 0, 0, 0, 100, -5, 7), 1'b1, '{128'd0, 1'b1}};
        directed[1]  = '{pack_word(0, 0, 0, 0, 32767, -32768, 32767), 1'b1,
                         '{128'd0, 1'b1}};
        // Unit quaternion, zero rate: all zeros, flag clear.
        directed[2]  = '{pack_word(0, 0, 0, 16384, 0, 0, 0), 1'b1, '{128'd0, 1'b0}};
        // Unit scalar part, omega_x = 1.0: rate_x = 0.5 (0x8000), others zero.
        directed[3]  = '{pack_word(0, 0, 0, 16384, 256, 0, 0), 1'b1,
                         '{{32'd0, 32'd0, 32'd0, 32'h8000}, 1'b0}};
        directed[4]  = '{pack_word(-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768), 1'b0, '{128'd0, 1'b0}};
        directed[5]  = '{pack_word(32767, 32767, 32767, 32767, 32767, 32767, 32767),
                         1'b0, '{128'd0, 1'b0}};
        // Tiny norm with huge omega drives every lane but rate_x into saturation.
        directed[6]  = '{pack_word(1, 0, 0, 0, 32767, -32768, 32767), 1'b0,
                         '{128'd0, 1'b0}};
        directed[7]  = '{pack_word(0, -1, 0, 0, -32768, 32767, -32768), 1'b0,
                         '{128'd0, 1'b0}};
        directed[8]  = '{pack_word(0, 0, 1, 1, 32767, 32767, 32767), 1'b0,
                         '{128'd0, 1'b0}};
        directed[9]  = '{pack_word(-32768, 0, 0, 0, 1, 1, 1), 1'b0, '{128'd0, 1'b0}};
        directed[10] = '{pack_word(3, -3, 3, -3, 1, -1, 1), 1'b0, '{128'd0, 1'b0}};
        directed[11] = '{pack_word(16384, 0, 0, 0, 0, 256, 0), 1'b0, '{128'd0, 1'b0}};
        directed[12] = '{pack_word(0, 16384, 0, 0, 0, 0, -256), 1'b0, '{128'd0, 1'b0}};
        directed[13] = '{pack_word(11585, -11585, 11585, -11585, 1234, -999, 77), 1'b0,
                         '{128'd0, 1'b0}};
    end

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [111:0] rand_word();
        logic [111:0] w;
        w = '0;
        for (int k = 0; k < 7; k++) w[k*16 +: 16] = rand_field();
        // Small norms now and then, and a zero quaternion rarely.
        case ($urandom_range(0, 19))
            0: w[63:0] = '0;
            1, 2: w[63:0] = {16'($urandom_range(0, 6)) - 16'd3,
                             16'($urandom_range(0, 6)) - 16'd3, 32'd0};
            default: ;
        endcase
        return w;
    endfunction

    // Drop valid while idling, hold the word until the handshake, return at a falling edge.
    task automatic send_word(logic [111:0] w, logic has_exp, rate_word_t exp);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rate_fifo.push_back(has_exp ? exp : quat_rate(w));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (rate_fifo.size() != 0) @(negedge aclk);
    endtask

    // Receiver: stall at random, check each word against the oldest expectation.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (rate_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: rates=%h zero_norm=%b", m_tdata, m_tuser);
            end else begin
                rate_word_t e;
                e = rate_fifo.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (m_tdata[k*32 +: 32] !== e.rates[k*32 +: 32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("rate %0d: expected %h got %h", k,
                                     e.rates[k*32 +: 32], m_tdata[k*32 +: 32]);
                    end
                end
                if (m_tuser !== e.zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("zero_norm: expected %b got %b", e.zero, m_tuser);
                end
            end
        end
    end

    // Watchdog on runaway runs.
    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("quaternion_rate_from_omega test failed");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(directed[i].word, directed[i].has_exp, directed[i].exp);

        // Walk the idling phases: none, sender idle, receiver stall, both, then none again.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                // Pause once per phase until the pipe is empty.
                if (i == 60) drain_results();
                send_word(rand_word(), 1'b0, '{128'd0, 1'b0});
            end
        end
        recv_stall_pct = 0;
        drain_results();
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && rate_fifo.size() == 0) begin
            $display("quaternion_rate_from_omega test passed");
        end else begin
            $display("quaternion_rate_from_omega test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
